@@ hw/rtl/pbc_pkg.sv @@
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types and constants for the playback position controller.
// ----------------------------------------------------------------------------
package pbc_pkg;

    localparam int POS_W               = 32;
    localparam int RATE_W              = 16;
    localparam int OP_W                = 3;
    localparam int MODE_W              = 2;
    localparam int CFG_IDX_W           = 2;
    localparam int RATE_FRAC_BITS_DEF  = 8;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

    typedef enum logic [OP_W-1:0] {
        OP_ADVANCE = 3'd0,
        OP_PLAY    = 3'd1,
        OP_PAUSE   = 3'd2,
        OP_RESUME  = 3'd3,
        OP_STOP    = 3'd4,
        OP_SET_POS = 3'd5,
        OP_RESTART = 3'd6
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOPPED = 2'd0,
        MODE_PLAYING = 2'd1,
        MODE_PAUSED  = 2'd2
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_AT_END = 2'd2;

endpackage

@@ hw/rtl/pbc_cmd_if.sv @@
// ----------------------------------------------------------------------------
// pbc_cmd_if
// Command channel: one request carries one playback command.
// ----------------------------------------------------------------------------
interface pbc_cmd_if
    import pbc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [POS_W-1:0]         duration;
    logic signed [POS_W-1:0]  tick_length;
    logic signed [POS_W-1:0]  new_position;

    modport source (
        output valid, operation, duration, tick_length, new_position,
        input  ready
    );

    modport sink (
        input  valid, operation, duration, tick_length, new_position,
        output ready
    );
endinterface

@@ hw/rtl/pbc_res_if.sv @@
// ----------------------------------------------------------------------------
// pbc_res_if
// Result channel: position and run mode after each command.
// ----------------------------------------------------------------------------
interface pbc_res_if
    import pbc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    current_position;
    logic [MODE_W-1:0]   current_mode;

    modport source (
        output valid, current_position, current_mode,
        input  ready
    );

    modport sink (
        input  valid, current_position, current_mode,
        output ready
    );
endinterface

@@ hw/rtl/pbc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// pbc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pbc_cfg_if
    import pbc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [RATE_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ hw/rtl/playback_position_controller.sv @@
// ----------------------------------------------------------------------------
// playback_position_controller
// Playback position (unsigned integer) and run mode, driven by commands.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                       | handshake
//  --------+-----+-----------------------------------------------+----------
//  cmd     | in  | operation, duration, tick_length, new_position | valid/ready
//  res     | out | current_position, current_mode                 | valid/ready
//  cfg     | in  | index, data                                    | valid/ready
//
//  One command at a time. Non-advance commands go from accept to ST_FIN,
//  then to the output register. Advance: a serial shift-add multiplier takes
//  one rate bit per cycle, then either a clamp or a restoring remainder by
//  duration, one quotient bit per cycle over SUM_W - RATE_FRAC_BITS quotient
//  bits (41 by default).
//  The output register lets the next command be accepted while a result waits.
//  rst_n clears mode, position and control registers at once (rate returns to
//  RATE_RESET); cfg is always ready.
module playback_position_controller
    import pbc_pkg::*;
#(
    parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pbc_cmd_if.sink    cmd,
    pbc_res_if.source  res,
    pbc_cfg_if.sink    cfg
);

    // sum = position * 2^RF + tick * rate, never overflows at this width
    localparam int SHIFT_W = POS_W + 1 + RATE_FRAC_BITS;
    localparam int PROD_W  = POS_W + RATE_W;
    localparam int SUM_W   = ((SHIFT_W > PROD_W) ? SHIFT_W : PROD_W) + 1;
    localparam int Q_W     = SUM_W - RATE_FRAC_BITS;
    localparam int CNT_W   = $clog2(Q_W);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(RATE_W - 1);
    localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(Q_W - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_CHK  = 6'b000100,
        ST_MOD  = 6'b001000,
        ST_FIX  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t                   state_reg,     state_next;
    logic [CNT_W-1:0]         cnt_reg,       cnt_next;
    logic [SUM_W-1:0]         acc_reg,       acc_next;
    logic [SUM_W-1:0]         mcand_reg,     mcand_next;
    logic [RATE_W-1:0]        mplier_reg,    mplier_next;
    logic [Q_W-1:0]           mag_reg,       mag_next;
    logic [POS_W-1:0]         rem_reg,       rem_next;
    logic                     neg_reg,       neg_next;
    logic [POS_W-1:0]         dur_reg,       dur_next;
    logic [POS_W-1:0]         res_pos_reg,   res_pos_next;
    mode_t                    res_mode_reg,  res_mode_next;
    logic [POS_W-1:0]         position_reg,  position_next;
    mode_t                    run_state_reg, run_state_next;
    logic                     out_valid_reg, out_valid_next;
    logic [POS_W-1:0]         out_pos_reg,   out_pos_next;
    mode_t                    out_mode_reg,  out_mode_next;
    logic [RATE_W-1:0]        rate_reg,      rate_next;
    logic                     wrap_reg,      wrap_next;
    logic                     hold_reg,      hold_next;

    logic [SUM_W-1:0]         partial;
    logic [Q_W-1:0]           quot;
    logic [POS_W:0]           trial;
    logic [POS_W:0]           trial_diff;
    mode_t                    end_mode;

    assign cmd.ready            = (state_reg == ST_IDLE);
    assign cfg.ready            = 1'b1;
    assign res.valid            = out_valid_reg;
    assign res.current_position = out_pos_reg;
    assign res.current_mode     = out_mode_reg;

    assign end_mode   = hold_reg ? MODE_PAUSED : MODE_STOPPED;
    assign partial    = mplier_reg[0] ? mcand_reg : '0;
    assign quot       = acc_reg[SUM_W-1:RATE_FRAC_BITS];
    assign trial      = {rem_reg, mag_reg[Q_W-1]};
    assign trial_diff = trial - {1'b0, dur_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        dur_next       = dur_reg;
        res_pos_next   = res_pos_reg;
        res_mode_next  = res_mode_reg;
        position_next  = position_reg;
        run_state_next = run_state_reg;
        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        out_mode_next  = out_mode_reg;
        rate_next      = rate_reg;
        wrap_next      = wrap_reg;
        hold_next      = hold_reg;

        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_RATE:        rate_next = cfg.data;
                CFG_WRAP_MODE:   wrap_next = cfg.data[0];
                CFG_HOLD_AT_END: hold_next = cfg.data[0];
                default:         ;
            endcase
        end

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    res_pos_next  = position_reg;
                    res_mode_next = run_state_reg;
                    dur_next      = cmd.duration;
                    acc_next      = {{(SUM_W-POS_W){1'b0}}, position_reg} << RATE_FRAC_BITS;
                    mcand_next    = {{(SUM_W-POS_W){cmd.tick_length[POS_W-1]}},
                                     cmd.tick_length};
                    mplier_next   = rate_reg;
                    cnt_next      = '0;
                    state_next    = ST_FIN;
                    case (cmd.operation)
                        OP_ADVANCE:
                        begin
                            if (run_state_reg == MODE_PLAYING && cmd.duration != '0 &&
                                cmd.tick_length != '0 && rate_reg != '0)
                            begin
                                state_next = ST_MUL;
                            end
                        end
                        OP_PLAY:
                        begin
                            res_mode_next = MODE_PLAYING;
                        end
                        OP_PAUSE:
                        begin
                            if (run_state_reg == MODE_PLAYING)
                            begin
                                res_mode_next = MODE_PAUSED;
                            end
                        end
                        OP_RESUME:
                        begin
                            if (run_state_reg == MODE_PAUSED)
                            begin
                                res_mode_next = MODE_PLAYING;
                            end
                        end
                        OP_STOP:
                        begin
                            res_mode_next = MODE_STOPPED;
                            res_pos_next  = '0;
                        end
                        OP_SET_POS:
                        begin
                            res_pos_next = cmd.new_position[POS_W-1] ? '0 : cmd.new_position;
                        end
                        OP_RESTART:
                        begin
                            res_mode_next = MODE_PLAYING;
                            res_pos_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end

            // top rate bit carries negative weight
            ST_MUL:
            begin
                acc_next    = (cnt_reg == MUL_LAST) ? acc_reg - partial : acc_reg + partial;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_CHK;
                end
            end

            ST_CHK:
            begin
                neg_next = acc_reg[SUM_W-1];
                if (wrap_reg)
                begin
                    // floor(S / 2^RF) mod duration equals the position
                    mag_next   = acc_reg[SUM_W-1] ? (~quot + 1'b1) : quot;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_MOD;
                end
                else
                begin
                    if (acc_reg[SUM_W-1] || acc_reg == '0)
                    begin
                        res_pos_next  = '0;
                        res_mode_next = end_mode;
                    end
                    else if (quot >= {{(Q_W-POS_W){1'b0}}, dur_reg})
                    begin
                        res_pos_next  = dur_reg;
                        res_mode_next = end_mode;
                    end
                    else
                    begin
                        res_pos_next = quot[POS_W-1:0];
                    end
                    state_next = ST_FIN;
                end
            end

            ST_MOD:
            begin
                rem_next = trial_diff[POS_W] ? trial[POS_W-1:0] : trial_diff[POS_W-1:0];
                mag_next = mag_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MOD_LAST)
                begin
                    state_next = ST_FIX;
                end
            end

            ST_FIX:
            begin
                res_pos_next = (neg_reg && rem_reg != '0) ? dur_reg - rem_reg : rem_reg;
                state_next   = ST_FIN;
            end

            ST_FIN:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = res_pos_reg;
                    out_mode_next  = res_mode_reg;
                    position_next  = res_pos_reg;
                    run_state_next = res_mode_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            position_reg  <= '0;
            run_state_reg <= MODE_STOPPED;
            out_valid_reg <= 1'b0;
            rate_reg      <= RATE_RESET;
            wrap_reg      <= 1'b0;
            hold_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            position_reg  <= position_next;
            run_state_reg <= run_state_next;
            out_valid_reg <= out_valid_next;
            rate_reg      <= rate_next;
            wrap_reg      <= wrap_next;
            hold_reg      <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        dur_reg      <= dur_next;
        res_pos_reg  <= res_pos_next;
        res_mode_reg <= res_mode_next;
        out_pos_reg  <= out_pos_next;
        out_mode_reg <= out_mode_next;
    end

endmodule

@@ hw/rtl/pbc_checker.sv @@
// ----------------------------------------------------------------------------
// pbc_checker
// Port-level checks for the playback position controller.
// ----------------------------------------------------------------------------
module pbc_checker
    import pbc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [POS_W-1:0]   res_position,
    input logic [MODE_W-1:0]  res_mode
);

    // a stalled result keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_position) && $stable(res_mode))
        else $error("result changed while stalled");

    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_mode == MODE_STOPPED || res_mode == MODE_PLAYING ||
                       res_mode == MODE_PAUSED))
        else $error("result carries an unused mode code");

    // one command in work at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second request taken while busy");

    // a new result only comes out of a command in work
    a_res_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!cmd_ready))
        else $error("result without a command");

endmodule

bind playback_position_controller pbc_checker u_pbc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_position (res.current_position),
    .res_mode     (res.current_mode)
);
